FILE: rtl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// shared types and register codes of the decimating box blur
// ----------------------------------------------------------------------------
package bbd_pkg;

    // input item: op selects pixel or drain
    typedef struct packed {
        logic        op;
        logic [15:0] pixel;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [15:0] blurred;
        logic        frame_end;
    } t_out_item;

    // classified item as queued between front and back
    typedef struct packed {
        logic        drain;
        logic [15:0] pixel;
    } t_q_item;

    // queue status towards the back end
    typedef struct packed {
        logic    valid;
        t_q_item item;
    } t_q_head;

    // configuration register indices
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;
    localparam logic [1:0] CFG_DECIM  = 2'd3;

    // reset values of the configuration registers
    localparam logic [11:0] RST_WIDTH  = 12'd2048;
    localparam logic [15:0] RST_HEIGHT = 16'd1024;
    localparam logic [4:0]  RST_RADIUS = 5'd1;
    localparam logic [3:0]  RST_DECIM  = 4'd1;

endpackage

FILE: rtl/box_blur_2d_decimating.sv
// ----------------------------------------------------------------------------
// box_blur_2d_decimating
// clipped square box blur with decimation over a raster pixel stream
// ----------------------------------------------------------------------------
//  channel   signals                               direction
//  input     i_valid  o_ready  i_data (op, pixel)  in
//  result    o_valid  i_ready  o_data              out
//  config    i_cfg_valid  o_cfg_ready  index/data  in, always ready
//
//  a pixel passes S_IDLE and S_PIX; at a row end S_TRD and S_TWR form the right edge sums
//  each output position passes S_OUT; a kept one reads each window row from the row sum
//  ring (one port), forms 29 quotient bits in S_DIV and goes to the result register
//  reset is synchronous; the row sum ring is always written before it is read in a frame
//  the front register and a four entry queue keep taking items, until the queue is full,
//  while the back end works or while a result waits in the output register
// ----------------------------------------------------------------------------
module box_blur_2d_decimating #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 16,
    parameter int PIXEL_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_valid,
    output logic               o_ready,
    input  bbd_pkg::t_in_item  i_data,
    // results
    output logic               o_valid,
    input  logic               i_ready,
    output bbd_pkg::t_out_item o_data,
    // register writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    logic             push;
    logic             q_ready;
    logic             pop;
    bbd_pkg::t_q_item f_item;
    bbd_pkg::t_q_head q_head;

    // the user must only issue register writes while idle; the block does not enforce it, so no back pressure
    assign o_cfg_ready = 1'b1;

    // front: input register and classification
    bbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_push    (push),
        .o_item    (f_item),
        .i_q_ready (q_ready)
    );

    // decoupling queue
    bbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_head  (q_head),
        .i_pop   (pop)
    );

    // back: row sums, column sums, division and result register
    bbd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

FILE: rtl/bbd_front.sv
// ----------------------------------------------------------------------------
// bbd_front
// input register: takes items and classifies them as pixel or drain
// ----------------------------------------------------------------------------
module bbd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bbd_pkg::t_in_item i_data,
    output logic              o_push,
    output bbd_pkg::t_q_item  o_item,
    input  logic              i_q_ready
);

    logic             r_valid;
    logic             n_valid;
    bbd_pkg::t_q_item r_item;

    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = (r_valid && !i_q_ready) || (i_valid && o_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.drain <= i_data.op;
            r_item.pixel <= i_data.pixel;
        end
    end

endmodule

FILE: rtl/bbd_queue.sv
// ----------------------------------------------------------------------------
// bbd_queue
// four entry queue between front and back end
// ----------------------------------------------------------------------------
module bbd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bbd_pkg::t_q_item  i_item,
    output logic              o_ready,
    output bbd_pkg::t_q_head  o_head,
    input  logic              i_pop
);

    bbd_pkg::t_q_item r_mem [4];
    logic [1:0]       r_wptr;
    logic [1:0]       r_rptr;
    logic [2:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready     = (r_count != 3'd4);
    assign do_push     = i_push && o_ready;
    assign do_pop      = i_pop && (r_count != 3'd0);
    assign o_head.valid = (r_count != 3'd0);
    assign o_head.item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 2'd1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 2'd1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 3'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

FILE: rtl/bbd_back.sv
// ----------------------------------------------------------------------------
// bbd_back
// sequencer: row sums, column accumulation, rounded division, result register
// ----------------------------------------------------------------------------
module bbd_back #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 16,
    parameter int PIXEL_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bbd_pkg::t_q_head   i_head,
    output logic               o_pop,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_ready,
    output bbd_pkg::t_out_item o_data
);

    localparam int XB   = $clog2(MAX_WIDTH);
    localparam int WB   = XB + 1;
    localparam int RB   = $clog2(MAX_RADIUS + 1);
    localparam int RING = 2 * MAX_RADIUS + 1;
    localparam int SLB  = $clog2(RING);
    localparam int NB   = $clog2(RING + 1);
    localparam int PB   = PIXEL_BITS;
    localparam int HB   = PB + $clog2(RING);
    localparam int AB   = HB + $clog2(RING);
    localparam int ARB  = 2 * NB;
    localparam int DB   = AB + 1;
    localparam int DCB  = $clog2(DB);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PIX  = 4'd1;
    localparam logic [3:0] S_TRD  = 4'd2;
    localparam logic [3:0] S_TWR  = 4'd3;
    localparam logic [3:0] S_OUT  = 4'd4;
    localparam logic [3:0] S_SRD  = 4'd5;
    localparam logic [3:0] S_SACC = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    // configuration
    logic [11:0] r_cfg_w;
    logic [15:0] r_cfg_h;
    logic [4:0]  r_cfg_r;
    logic [3:0]  r_cfg_s;

    logic [WB-1:0] w_eff;
    logic [15:0]   h_eff;
    logic [RB-1:0] r_eff;
    logic [RB-1:0] rh;
    logic [RB-1:0] rv;
    logic [NB-1:0] nh;
    logic [NB-1:0] nv;
    logic [3:0]    s_eff;
    logic [31:0]   w32, h32, rh32, rv32, s32, nh32, nv32;

    // control state
    logic [3:0]     r_state, n_state;
    logic [15:0]    r_in_row, n_in_row;
    logic [XB-1:0]  r_in_col, n_in_col;
    logic [SLB-1:0] r_in_slot, n_in_slot;
    logic [SLB-1:0] r_pslot, n_pslot;
    logic [15:0]    r_out_row, n_out_row;
    logic [XB-1:0]  r_out_col, n_out_col;
    logic [SLB-1:0] r_out_slot, n_out_slot;
    logic [3:0]     r_rmod, n_rmod;
    logic [3:0]     r_cmod, n_cmod;
    logic           r_process, n_process;
    logic [SLB-1:0] r_tslot, n_tslot;
    logic [XB-1:0]  r_tcol, n_tcol;
    logic [SLB-1:0] r_rd_slot, n_rd_slot;
    logic [NB-1:0]  r_rd_cnt, n_rd_cnt;
    logic [DCB-1:0] r_dcnt, n_dcnt;
    logic           r_out_valid, n_out_valid;

    // datapath
    logic [PB-1:0]  r_pix, n_pix;
    logic [HB-1:0]  r_rs, n_rs;
    logic [HB-1:0]  r_tsum, n_tsum;
    logic [AB-1:0]  r_acc, n_acc;
    logic [ARB-1:0] r_area, n_area;
    logic           r_last, n_last;
    logic [DB-1:0]  r_num, n_num;
    logic [ARB-1:0] r_rem, n_rem;
    bbd_pkg::t_out_item r_out, n_out;

    // memories
    logic [PB-1:0]  pw_mem [RING];
    logic [PB-1:0]  r_pw_rd;
    logic [SLB-1:0] pw_raddr;
    logic           pw_we;
    logic [HB-1:0]  hs_mem [RING][MAX_WIDTH];
    logic [HB-1:0]  r_hs_rd;
    logic           hs_we;
    logic [SLB-1:0] hs_wslot;
    logic [XB-1:0]  hs_wcol;
    logic [HB-1:0]  hs_wdata;

    // working values
    logic [31:0]    i32, c32, x32, d_up, d_dn, l_c, r_c, rows, cols;
    logic           kept, last, col_end, do_adv, do_restart;
    logic [SLB-1:0] start_slot;
    logic [HB-1:0]  rs_new, tsum_new;
    logic [AB-1:0]  acc_new;
    logic [ARB:0]   rem_sh;
    logic           rem_ge;
    logic           proc_now;
    logic [SLB-1:0] pslot_nx;

    // effective register values
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WB'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(r_cfg_w);
        end
        h_eff = (r_cfg_h == '0) ? 16'd1 : r_cfg_h;
        r_eff = (32'(r_cfg_r) > MAX_RADIUS) ? RB'(MAX_RADIUS) : RB'(r_cfg_r);
        w32   = 32'(w_eff);
        h32   = 32'(h_eff);
        rh    = (32'(r_eff) < w32 - 1) ? r_eff : RB'(w32 - 1);
        rv    = (32'(r_eff) < h32 - 1) ? r_eff : RB'(h32 - 1);
        nh    = NB'({rh, 1'b1});
        nv    = NB'({rv, 1'b1});
        s_eff = (r_cfg_s == '0) ? 4'd1 : r_cfg_s;
        rh32  = 32'(rh);
        rv32  = 32'(rv);
        nh32  = 32'(nh);
        nv32  = 32'(nv);
        s32   = 32'(s_eff);
    end

    assign pw_raddr = (r_state == S_TRD || r_state == S_TWR) ? r_tslot : r_pslot;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // window geometry of the current output position
    always_comb begin
        i32     = 32'(r_out_row);
        c32     = 32'(r_out_col);
        d_up    = (i32 >= rv32) ? rv32 : i32;
        d_dn    = (i32 + rv32 < h32 - 1) ? rv32 : h32 - 1 - i32;
        l_c     = (c32 >= rh32) ? rh32 : c32;
        r_c     = (c32 + rh32 < w32 - 1) ? rh32 : w32 - 1 - c32;
        rows    = d_up + d_dn + 1;
        cols    = l_c + r_c + 1;
        kept    = (r_rmod == '0) && (r_cmod == '0) && (c32 + s32 <= w32);
        last    = kept && (i32 + s32 >= h32) && (c32 + 2 * s32 > w32);
        start_slot = (32'(r_out_slot) >= d_up) ? SLB'(32'(r_out_slot) - d_up)
                                               : SLB'(32'(r_out_slot) + nv32 - d_up);
        col_end = (c32 + 1 >= w32);
    end

    // input side, accumulation and division arithmetic
    always_comb begin
        x32      = 32'(r_in_col);
        rs_new   = ((r_in_col == '0) ? '0 : r_rs) + HB'(r_pix)
                   - ((x32 >= nh32) ? HB'(r_pw_rd) : '0);
        proc_now = (32'(r_in_row) > rv32) || ((32'(r_in_row) == rv32) && (x32 >= rh32));
        pslot_nx = (32'(r_pslot) + 1 >= nh32) ? '0 : r_pslot + SLB'(1);
        tsum_new = r_tsum - ((32'(r_tcol) >= rh32 + 1) ? HB'(r_pw_rd) : '0);
        acc_new  = r_acc + AB'(r_hs_rd);
        rem_sh   = {r_rem, r_num[DB-1]};
        rem_ge   = (rem_sh >= {1'b0, r_area});
    end

    always_comb begin
        n_state     = r_state;
        n_in_row    = r_in_row;
        n_in_col    = r_in_col;
        n_in_slot   = r_in_slot;
        n_pslot     = r_pslot;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_slot  = r_out_slot;
        n_rmod      = r_rmod;
        n_cmod      = r_cmod;
        n_process   = r_process;
        n_tslot     = r_tslot;
        n_tcol      = r_tcol;
        n_rd_slot   = r_rd_slot;
        n_rd_cnt    = r_rd_cnt;
        n_dcnt      = r_dcnt;
        n_out_valid = r_out_valid && !i_ready;
        n_pix       = r_pix;
        n_rs        = r_rs;
        n_tsum      = r_tsum;
        n_acc       = r_acc;
        n_area      = r_area;
        n_last      = r_last;
        n_num       = r_num;
        n_rem       = r_rem;
        n_out       = r_out;
        pw_we       = 1'b0;
        hs_we       = 1'b0;
        hs_wslot    = r_in_slot;
        hs_wcol     = r_tcol;
        hs_wdata    = tsum_new;
        do_adv      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    if (r_in_row < h_eff) begin
                        if (!i_head.item.drain) begin
                            n_pix   = PB'(i_head.item.pixel);
                            n_state = S_PIX;
                        end
                    end else if (r_out_row < h_eff) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_PIX: begin
                pw_we     = 1'b1;
                n_rs      = rs_new;
                n_process = proc_now;
                if (x32 >= rh32) begin
                    hs_we    = 1'b1;
                    hs_wcol  = XB'(x32 - rh32);
                    hs_wdata = rs_new;
                end
                if (x32 + 1 >= w32) begin
                    if (rh == '0) begin
                        n_in_col  = '0;
                        n_in_row  = r_in_row + 16'd1;
                        n_in_slot = (32'(r_in_slot) + 1 >= nv32) ? '0
                                                                 : r_in_slot + SLB'(1);
                        n_pslot   = '0;
                        n_state   = proc_now ? S_OUT : S_IDLE;
                    end else begin
                        n_tcol  = XB'(w32 - rh32);
                        n_tsum  = rs_new;
                        n_tslot = pslot_nx;
                        n_state = S_TRD;
                    end
                end else begin
                    n_in_col = r_in_col + XB'(1);
                    n_pslot  = pslot_nx;
                    n_state  = proc_now ? S_OUT : S_IDLE;
                end
            end
            S_TRD: begin
                n_state = S_TWR;
            end
            S_TWR: begin
                hs_we   = 1'b1;
                n_tsum  = tsum_new;
                n_tslot = (32'(r_tslot) + 1 >= nh32) ? '0 : r_tslot + SLB'(1);
                n_tcol  = r_tcol + XB'(1);
                if (32'(r_tcol) + 1 >= w32) begin
                    n_in_col  = '0;
                    n_in_row  = r_in_row + 16'd1;
                    n_in_slot = (32'(r_in_slot) + 1 >= nv32) ? '0 : r_in_slot + SLB'(1);
                    n_pslot   = '0;
                    n_state   = r_process ? S_OUT : S_IDLE;
                end else begin
                    n_state = S_TRD;
                end
            end
            S_OUT: begin
                if (kept) begin
                    n_rd_slot = start_slot;
                    n_rd_cnt  = NB'(rows - 1);
                    n_acc     = '0;
                    n_area    = ARB'(rows) * ARB'(cols);
                    n_last    = last;
                    n_state   = S_SRD;
                end else begin
                    do_adv  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SRD: begin
                n_state = S_SACC;
            end
            S_SACC: begin
                if (r_rd_cnt == '0) begin
                    n_num   = DB'(acc_new) + DB'(r_area >> 1);
                    n_rem   = '0;
                    n_dcnt  = DCB'(DB - 1);
                    n_state = S_DIV;
                end else begin
                    n_acc     = acc_new;
                    n_rd_cnt  = r_rd_cnt - NB'(1);
                    n_rd_slot = (32'(r_rd_slot) + 1 >= nv32) ? '0 : r_rd_slot + SLB'(1);
                    n_state   = S_SRD;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit a cycle
                n_rem  = rem_ge ? ARB'(rem_sh - {1'b0, r_area}) : ARB'(rem_sh);
                n_num  = {r_num[DB-2:0], rem_ge};
                n_dcnt = r_dcnt - DCB'(1);
                if (r_dcnt == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out.blurred   = r_num[15:0];
                    n_out.frame_end = r_last;
                    n_out_valid     = 1'b1;
                    do_adv          = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        do_restart = do_adv && col_end && (i32 + 1 >= h32);
        if (do_adv) begin
            if (col_end) begin
                n_out_col  = '0;
                n_cmod     = '0;
                n_out_row  = r_out_row + 16'd1;
                n_out_slot = (32'(r_out_slot) + 1 >= nv32) ? '0 : r_out_slot + SLB'(1);
                n_rmod     = (32'(r_rmod) + 1 >= s32) ? '0 : r_rmod + 4'd1;
            end else begin
                n_out_col = r_out_col + XB'(1);
                n_cmod    = (32'(r_cmod) + 1 >= s32) ? '0 : r_cmod + 4'd1;
            end
        end
        if (do_restart || i_cfg_valid) begin
            n_in_row   = '0;
            n_in_col   = '0;
            n_in_slot  = '0;
            n_pslot    = '0;
            n_out_row  = '0;
            n_out_col  = '0;
            n_out_slot = '0;
            n_rmod     = '0;
            n_cmod     = '0;
            n_rs       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= bbd_pkg::RST_WIDTH;
            r_cfg_h     <= bbd_pkg::RST_HEIGHT;
            r_cfg_r     <= bbd_pkg::RST_RADIUS;
            r_cfg_s     <= bbd_pkg::RST_DECIM;
            r_state     <= S_IDLE;
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_in_slot   <= '0;
            r_pslot     <= '0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_slot  <= '0;
            r_rmod      <= '0;
            r_cmod      <= '0;
            r_process   <= 1'b0;
            r_tslot     <= '0;
            r_tcol      <= '0;
            r_rd_slot   <= '0;
            r_rd_cnt    <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
            r_rs        <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bbd_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data[11:0];
                    bbd_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                    bbd_pkg::CFG_RADIUS: r_cfg_r <= i_cfg_data[4:0];
                    bbd_pkg::CFG_DECIM:  r_cfg_s <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            r_state     <= n_state;
            r_in_row    <= n_in_row;
            r_in_col    <= n_in_col;
            r_in_slot   <= n_in_slot;
            r_pslot     <= n_pslot;
            r_out_row   <= n_out_row;
            r_out_col   <= n_out_col;
            r_out_slot  <= n_out_slot;
            r_rmod      <= n_rmod;
            r_cmod      <= n_cmod;
            r_process   <= n_process;
            r_tslot     <= n_tslot;
            r_tcol      <= n_tcol;
            r_rd_slot   <= n_rd_slot;
            r_rd_cnt    <= n_rd_cnt;
            r_dcnt      <= n_dcnt;
            r_out_valid <= n_out_valid;
            r_rs        <= n_rs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix  <= n_pix;
        r_tsum <= n_tsum;
        r_acc  <= n_acc;
        r_area <= n_area;
        r_last <= n_last;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_out  <= n_out;
    end

    // pixel window of the current row
    always_ff @(posedge i_clk) begin
        if (pw_we) begin
            pw_mem[r_pslot] <= r_pix;
        end
        r_pw_rd <= pw_mem[pw_raddr];
    end

    // ring of horizontal window sums
    always_ff @(posedge i_clk) begin
        if (hs_we) begin
            hs_mem[hs_wslot][hs_wcol] <= hs_wdata;
        end
        r_hs_rd <= hs_mem[r_rd_slot][r_out_col];
    end

endmodule

FILE: rtl/bbd_checker.sv
// ----------------------------------------------------------------------------
// bbd_checker
// port level checks of the box blur, bound to the top level
// ----------------------------------------------------------------------------
module bbd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input bbd_pkg::t_out_item o_data,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // register port never back-pressures
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("register write stalled");

endmodule

bind box_blur_2d_decimating bbd_checker u_bbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_data      (o_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);
